// File: rtl/gpsf_pkg.sv
// ----------------------------------------------------------------------------
// gpsf_pkg
// Shared types and constants for the packet stream filter: marker characters,
// filter modes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package gpsf_pkg;

  // default capacity of the capture store in bytes
  localparam int PACKET_MAX_DEF = 32;

  // protocol marker characters
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH   = 8'h23;

  // filter mode: pass, packet data, first and second checksum character
  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_DATA,
    MODE_CK1,
    MODE_CK2
  } filt_mode_t;

  // output sequencer
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REPLAY,
    ST_TAIL
  } seq_state_t;

endpackage

`default_nettype wire

// File: rtl/gpsf_store.sv
// ----------------------------------------------------------------------------
// gpsf_store
// Capture store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gpsf_store #(
  parameter int DEPTH = gpsf_pkg::PACKET_MAX_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data_r
);

  logic [7:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/gdb_packet_stream_filter.sv
// ----------------------------------------------------------------------------
// gdb_packet_stream_filter
// Strips remote debug packets of the form '+$data#xx' from a console byte
// stream. Captured bytes go to a store and are replayed if the packet breaks.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   in_       input      in_valid / in_ready     in_data_byte[7:0]
//   out_      output     out_valid / out_ready   out_out_byte[7:0], out_last
//
// Unless the output stalls, a byte that gives zero or one output word is taken
// every cycle, and a replay of N stored bytes streams one word per cycle from
// the store's single read port, holding the input until it ends. A byte that
// gives two words (held '+' then another byte) holds the input for the second.
// rst_n is synchronous and active low; the store needs no clearing.
// out_ready low stalls the output register and with it the input.
// ----------------------------------------------------------------------------
`default_nettype none

module gdb_packet_stream_filter #(
  parameter int PACKET_MAX = gpsf_pkg::PACKET_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_data_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] out_out_byte,
  output logic            out_last
);

  import gpsf_pkg::*;

  localparam int AW    = $clog2(PACKET_MAX);
  localparam int CNT_W = $clog2(PACKET_MAX + 1);

  // control registers
  seq_state_t       state_r, state_nxt;
  filt_mode_t       mode_r, mode_nxt;
  logic             plus_r, plus_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rep_len_r, rep_len_nxt;
  logic [CNT_W-1:0] rd_idx_r, rd_idx_nxt;
  logic             rd_vld_r, rd_vld_nxt;
  logic             rd_last_r, rd_last_nxt;
  logic             tail_pend_r, tail_pend_nxt;
  logic [7:0]       tail0_r, tail0_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  // per-byte decode
  logic             rep;
  logic [CNT_W-1:0] rep_len;
  logic [1:0]       n_tail;
  logic [7:0]       t0, t1;
  logic             out_free;

  // store ports
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic             rd_en;
  logic [7:0]       rd_data;

  // only an accepted byte is written
  gpsf_store #(
    .DEPTH (PACKET_MAX)
  ) u_store (
    .clk       (clk),
    .wr_en     (wr_en && in_valid && in_ready),
    .wr_addr   (wr_addr),
    .wr_data   (in_data_byte),
    .rd_en     (rd_en),
    .rd_addr   (rd_idx_r[AW-1:0]),
    .rd_data_r (rd_data)
  );

  assign out_free     = !out_valid_r || out_ready;
  assign in_ready     = (state_r == ST_IDLE) && out_free;
  assign out_valid    = out_valid_r;
  assign out_out_byte = out_byte_r;
  assign out_last     = out_last_r;

  // decode of one input byte against mode and held '+'
  always_comb begin
    rep       = 1'b0;
    rep_len   = count_r;
    n_tail    = 2'd0;
    t0        = in_data_byte;
    t1        = in_data_byte;
    mode_nxt  = mode_r;
    plus_nxt  = plus_r;
    count_nxt = count_r;
    wr_en     = 1'b0;
    wr_addr   = count_r[AW-1:0];
    if (mode_r != MODE_PASS && count_r == CNT_W'(PACKET_MAX)) begin
      // store full: replay, then treat the byte as in pass mode with nothing held
      rep       = 1'b1;
      mode_nxt  = MODE_PASS;
      count_nxt = '0;
      if (in_data_byte == CH_PLUS) begin
        plus_nxt = 1'b1;
      end else begin
        plus_nxt = 1'b0;
        n_tail   = 2'd1;
      end
    end else begin
      case (mode_r)
        MODE_PASS: begin
          if (!plus_r) begin
            if (in_data_byte == CH_PLUS) begin
              plus_nxt = 1'b1;
            end else begin
              n_tail = 2'd1;
            end
          end else if (in_data_byte == CH_DOLLAR) begin
            // packet start: drop the '+', store the '$'
            plus_nxt  = 1'b0;
            wr_en     = 1'b1;
            wr_addr   = '0;
            count_nxt = CNT_W'(1);
            mode_nxt  = MODE_DATA;
          end else if (in_data_byte == CH_PLUS) begin
            n_tail = 2'd1;
            t0     = CH_PLUS;
          end else begin
            plus_nxt = 1'b0;
            n_tail   = 2'd2;
            t0       = CH_PLUS;
          end
        end
        MODE_DATA: begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (in_data_byte == CH_HASH) begin
            mode_nxt = MODE_CK1;
          end else if (in_data_byte == CH_DOLLAR) begin
            // broken packet: replay everything including this '$'
            rep       = 1'b1;
            rep_len   = count_r + CNT_W'(1);
            mode_nxt  = MODE_PASS;
            count_nxt = '0;
            plus_nxt  = 1'b0;
          end
        end
        MODE_CK1: begin
          wr_en     = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          mode_nxt  = MODE_CK2;
        end
        default: begin
          // second checksum char: packet complete, discard
          count_nxt = '0;
          mode_nxt  = MODE_PASS;
        end
      endcase
    end
  end

  // sequencer, replay read pipeline and output register
  always_comb begin
    state_nxt     = state_r;
    rep_len_nxt   = rep_len_r;
    rd_idx_nxt    = rd_idx_r;
    rd_vld_nxt    = rd_vld_r;
    rd_last_nxt   = rd_last_r;
    tail_pend_nxt = tail_pend_r;
    tail0_nxt     = tail0_r;
    rd_en         = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          if (rep) begin
            state_nxt     = ST_REPLAY;
            rep_len_nxt   = rep_len;
            rd_idx_nxt    = '0;
            rd_vld_nxt    = 1'b0;
            tail_pend_nxt = (n_tail != 2'd0);
            tail0_nxt     = t0;
          end else if (n_tail != 2'd0) begin
            out_valid_nxt = 1'b1;
            out_byte_nxt  = t0;
            out_last_nxt  = (n_tail == 2'd1);
            if (n_tail == 2'd2) begin
              state_nxt     = ST_TAIL;
              tail_pend_nxt = 1'b1;
              tail0_nxt     = t1;
            end
          end
        end
      end
      ST_REPLAY: begin
        // hand the fetched byte to the output register
        if (rd_vld_r && out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = rd_data;
          out_last_nxt  = rd_last_r && !tail_pend_r;
          rd_vld_nxt    = 1'b0;
        end
        // fetch the next byte when the read register is free or being drained
        if (rd_idx_r != rep_len_r && (!rd_vld_r || out_free)) begin
          rd_en       = 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = (rd_idx_r == rep_len_r - CNT_W'(1));
          rd_idx_nxt  = rd_idx_r + CNT_W'(1);
        end
        if (rd_idx_r == rep_len_r && !rd_vld_r) begin
          state_nxt = tail_pend_r ? ST_TAIL : ST_IDLE;
        end
      end
      ST_TAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = tail0_r;
          out_last_nxt  = 1'b1;
          tail_pend_nxt = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // filter state updates only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_PASS;
      plus_r  <= 1'b0;
      count_r <= '0;
    end else if (in_valid && in_ready) begin
      mode_r  <= mode_nxt;
      plus_r  <= plus_nxt;
      count_r <= count_nxt;
    end
  end

  // sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_vld_r    <= 1'b0;
      tail_pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      rd_idx_r    <= '0;
      rep_len_r   <= '0;
      rd_last_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_vld_r    <= rd_vld_nxt;
      tail_pend_r <= tail_pend_nxt;
      out_valid_r <= out_valid_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rep_len_r   <= rep_len_nxt;
      rd_last_r   <= rd_last_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    tail0_r    <= tail0_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

`default_nettype wire
